// File: sv/lzre_pkg.sv
package lzre_pkg;

  localparam int WinAw = 18;
  localparam int LitAw = 17;
  localparam int PosW = 19;
  localparam logic [PosW-1:0] WinBytes = 19'd262144;
  localparam logic [LitAw:0] LitBytes = 18'd131072;
  localparam logic signed [PosW-1:0] OffReset = -19'sd8;

  localparam logic [2:0] OpPush = 3'd0;
  localparam logic [2:0] OpCmd = 3'd1;
  localparam logic [2:0] OpFinish = 3'd2;
  localparam logic [2:0] OpHist = 3'd3;
  localparam logic [2:0] OpRead = 3'd4;

  localparam logic [2:0] StOk = 3'd0;
  localparam logic [2:0] StOffset = 3'd1;
  localparam logic [2:0] StLength = 3'd2;
  localparam logic [2:0] StStream = 3'd3;
  localparam logic [2:0] StLitCount = 3'd4;
  localparam logic [2:0] StOverrun = 3'd5;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;   // latch the item fields
    logic push;      // store one literal
    logic hist;      // write one raw history byte
    logic rd_issue;  // start a window read
    logic commit;    // apply offset cache and counters of a command
    logic lit_rd;    // read literal store and delta source
    logic lit_wr;    // write one literal into the window
    logic mat_rd;    // read match source
    logic mat_wr;    // write one match byte
    logic clear;     // finish: reset chunk state
    logic set_tail;  // finish: load tail length as literal length
    logic done;      // present the result
    logic [2:0] st;  // status for the result
    logic rb_sel;    // result carries the read byte
  } lzre_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic [2:0] op;
    logic [2:0] chk;    // command check result
    logic [2:0] fchk;   // finish check result
    logic lit_left;     // literals of the run still to copy
    logic mat_left;     // match bytes still to copy
    logic lit_full;
    logic win_full;
  } lzre_stat_t;

endpackage

// File: sv/lz_run_executor_recent_offsets_top.sv
// Push, history write, unused codes and failed checks give their result from the decode
// state; a read waits on the window read; a command copies its literals then its match
// bytes, a finish its tail, each byte a read then a write on the single window port.
// One item at a time; the result strobe is high one cycle and cannot be held off.
// Synchronous reset clears the offset cache, counters and configuration; the
// window and literal store hold no reset.
module lz_run_executor_recent_offsets_top import lzre_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  opcode,
  input  logic [7:0]  data_byte,
  input  logic [7:0]  cmd_byte,
  input  logic [18:0] long_lit_len,
  input  logic [18:0] long_match_len,
  input  logic signed [18:0] new_offset,
  input  logic [17:0] read_addr,
  input  logic [18:0] expected_offsets,
  input  logic [18:0] expected_lengths,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [18:0] cfg_data,
  output logic        strobe,
  output logic [2:0]  status,
  output logic [18:0] position,
  output logic [7:0]  read_byte
);

  lzre_cmd_t  cmd;
  lzre_stat_t stat;

  lzre_ctrl u_ctrl (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .stat(stat), .cmd(cmd)
  );

  lzre_datapath u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .stat(stat),
    .opcode(opcode), .data_byte(data_byte), .cmd_byte(cmd_byte),
    .long_lit_len(long_lit_len), .long_match_len(long_match_len),
    .new_offset(new_offset), .read_addr(read_addr),
    .expected_offsets(expected_offsets), .expected_lengths(expected_lengths),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .strobe(strobe), .status(status), .position(position), .read_byte(read_byte)
  );

endmodule

// File: sv/lzre_ctrl.sv
module lzre_ctrl import lzre_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  output logic       busy,
  input  lzre_stat_t stat,
  output lzre_cmd_t  cmd
);

  typedef enum logic [8:0] {
    S_IDLE  = 9'b000000001,
    S_DEC   = 9'b000000010,
    S_LRD   = 9'b000000100,
    S_LWR   = 9'b000001000,
    S_MRD   = 9'b000010000,
    S_MWR   = 9'b000100000,
    S_RDW   = 9'b001000000,
    S_RDO   = 9'b010000000,
    S_FIN   = 9'b100000000
  } state_t;

  state_t state, state_next;
  logic   fin;
  logic   fin_next;

  assign busy = (state != S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      fin <= 1'b0;
    end else begin
      state <= state_next;
      fin <= fin_next;
    end
  end

  // Sequencer: at most one window access per cycle.
  always_comb begin
    cmd = '0;
    state_next = state;
    fin_next = fin;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          cmd.capture = 1'b1;
          state_next = S_DEC;
        end
      end
      S_DEC: begin
        unique case (stat.op)
          OpPush: begin
            cmd.push = !stat.lit_full;
            cmd.st = stat.lit_full ? StOverrun : StOk;
            cmd.done = 1'b1;
            state_next = S_IDLE;
          end
          OpHist: begin
            cmd.hist = !stat.win_full;
            cmd.st = stat.win_full ? StLength : StOk;
            cmd.done = 1'b1;
            state_next = S_IDLE;
          end
          OpRead: begin
            cmd.rd_issue = 1'b1;
            state_next = S_RDW;
          end
          OpCmd: begin
            if (stat.chk != StOk) begin
              cmd.st = stat.chk;
              cmd.done = 1'b1;
              state_next = S_IDLE;
            end else begin
              fin_next = 1'b0;
              state_next = S_LRD;
            end
          end
          OpFinish: begin
            if (stat.fchk != StOk) begin
              cmd.st = stat.fchk;
              cmd.clear = 1'b1;
              cmd.done = 1'b1;
              state_next = S_IDLE;
            end else begin
              cmd.set_tail = 1'b1;
              fin_next = 1'b1;
              state_next = S_LRD;
            end
          end
          default: begin
            cmd.done = 1'b1;
            state_next = S_IDLE;
          end
        endcase
      end
      S_LRD: begin
        if (stat.lit_left) begin
          cmd.lit_rd = 1'b1;
          state_next = S_LWR;
        end else if (fin) begin
          cmd.clear = 1'b1;
          cmd.done = 1'b1;
          state_next = S_IDLE;
        end else begin
          cmd.commit = 1'b1;
          state_next = S_MRD;
        end
      end
      S_LWR: begin
        cmd.lit_wr = 1'b1;
        state_next = S_LRD;
      end
      S_MRD: begin
        if (stat.mat_left) begin
          cmd.mat_rd = 1'b1;
          state_next = S_MWR;
        end else begin
          cmd.done = 1'b1;
          state_next = S_IDLE;
        end
      end
      S_MWR: begin
        cmd.mat_wr = 1'b1;
        state_next = S_MRD;
      end
      S_RDW: state_next = S_RDO;
      S_RDO: begin
        cmd.rb_sel = 1'b1;
        cmd.done = 1'b1;
        state_next = S_IDLE;
      end
      S_FIN: state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

`ifndef SYNTHESIS
  a_no_start_busy: assert property (@(posedge clk) disable iff (rst)
    cmd.capture |-> !busy) else $error("capture while busy");
  a_done_ends: assert property (@(posedge clk) disable iff (rst)
    cmd.done |=> !busy) else $error("busy after result");
  a_wr_follows_rd: assert property (@(posedge clk) disable iff (rst)
    cmd.lit_rd |=> cmd.lit_wr) else $error("literal write missing");
`endif

endmodule

// File: sv/lzre_datapath.sv
module lzre_datapath import lzre_pkg::*; (
  input  logic            clk,
  input  logic            rst,
  input  lzre_cmd_t       cmd,
  output lzre_stat_t      stat,
  input  logic [2:0]      opcode,
  input  logic [7:0]      data_byte,
  input  logic [7:0]      cmd_byte,
  input  logic [18:0]     long_lit_len,
  input  logic [18:0]     long_match_len,
  input  logic signed [18:0] new_offset,
  input  logic [17:0]     read_addr,
  input  logic [18:0]     expected_offsets,
  input  logic [18:0]     expected_lengths,
  input  logic            cfg_we,
  input  logic            cfg_index,
  input  logic [18:0]     cfg_data,
  output logic            strobe,
  output logic [2:0]      status,
  output logic [18:0]     position,
  output logic [7:0]      read_byte
);

  localparam int WINDOW_DEPTH_C = 1 << WinAw;
  localparam int LIT_DEPTH_C = 1 << LitAw;
  logic [7:0] win_mem [WINDOW_DEPTH_C];
  logic [7:0] lit_mem [LIT_DEPTH_C];

  // Configuration.
  logic        lit_mode;
  logic [18:0] chunk_end;

  // Captured item.
  logic [2:0]  op_q;
  logic [7:0]  data_q, cmd_q;
  logic [18:0] llen_q, mlen_q, eo_q, el_q;
  logic signed [18:0] noff_q;
  logic [17:0] ra_q;

  // Chunk state.
  logic [LitAw:0] lit_cnt, lit_pos;
  logic [18:0] wpos, offs_cons, lens_cons;
  logic signed [18:0] rec0, rec1, rec2, last_off;

  // Run counters.
  logic [18:0] lit_rem;
  logic [19:0] mat_rem;
  logic signed [18:0] run_off;
  logic [7:0] lit_b, src_b, rd_q;
  logic       src_ok;

  // Decode and checks, all from registered values.
  logic [1:0]  lcode, oidx;
  logic [3:0]  mcode;
  logic [18:0] litlen, limit;
  logic [19:0] matchlen, after;
  logic [20:0] after_m;
  logic signed [18:0] off_sel;
  logic [19:0] off_mag;
  logic [19:0] lit_need;
  logic [18:0] lit_avail;

  assign lcode = cmd_q[1:0];
  assign mcode = cmd_q[5:2];
  assign oidx = cmd_q[7:6];
  assign litlen = (lcode == 2'd3) ? llen_q : {17'd0, lcode};
  assign matchlen = (mcode == 4'hF) ? ({1'b0, mlen_q} + 20'd14) : {14'd0, mcode} + 20'd2;
  assign limit = (chunk_end < WinBytes) ? chunk_end : WinBytes;
  assign after = {1'b0, wpos} + {1'b0, litlen};
  assign after_m = {1'b0, after} + {1'b0, matchlen};
  assign lit_need = {1'b0, {(18-LitAw){1'b0}}, lit_pos} + {1'b0, litlen};
  assign lit_avail = 19'(lit_cnt - lit_pos);

  always_comb begin
    unique case (oidx)
      2'd0: off_sel = rec0;
      2'd1: off_sel = rec1;
      2'd2: off_sel = rec2;
      default: off_sel = noff_q;
    endcase
  end
  assign off_mag = 20'(-{off_sel[18], off_sel});

  always_comb begin
    if (lit_need > {1'b0, {(18-LitAw){1'b0}}, lit_cnt}) stat.chk = StOverrun;
    else if (after > {1'b0, limit}) stat.chk = StLength;
    else if (!off_sel[18] || off_mag > after) stat.chk = StOffset;
    else if (after_m > {2'b0, limit}) stat.chk = StLength;
    else stat.chk = StOk;
  end

  always_comb begin
    if (offs_cons != eo_q || lens_cons != el_q) stat.fchk = StStream;
    else if (wpos > limit || (limit - wpos) != lit_avail) stat.fchk = StLitCount;
    else stat.fchk = StOk;
  end

  assign stat.op = op_q;
  assign stat.lit_left = (lit_rem != '0);
  assign stat.mat_left = (mat_rem != '0);
  assign stat.lit_full = (lit_cnt >= LitBytes);
  assign stat.win_full = (wpos >= WinBytes);

  // Source addresses for the copy loops.
  logic [19:0] dsrc, msrc;
  assign dsrc = 20'({1'b0, wpos} + {run_off[18], run_off});
  assign msrc = 20'({1'b0, wpos} + {run_off[18], run_off});

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      lit_mode <= 1'b1;
      chunk_end <= '0;
    end else if (cfg_we) begin
      if (cfg_index) chunk_end <= cfg_data;
      else lit_mode <= cfg_data[0];
    end
  end

  // Item capture.
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_q <= opcode;
      data_q <= data_byte;
      cmd_q <= cmd_byte;
      llen_q <= long_lit_len;
      mlen_q <= long_match_len;
      noff_q <= new_offset;
      ra_q <= read_addr;
      eo_q <= expected_offsets;
      el_q <= expected_lengths;
    end
  end

  // Memories.
  always_ff @(posedge clk) begin
    if (cmd.push) lit_mem[lit_cnt[LitAw-1:0]] <= data_q;
    if (cmd.lit_rd) lit_b <= lit_mem[lit_pos[LitAw-1:0]];
  end

  always_ff @(posedge clk) begin
    if (cmd.hist) win_mem[wpos[WinAw-1:0]] <= data_q;
    else if (cmd.lit_wr) win_mem[wpos[WinAw-1:0]] <= (!lit_mode && src_ok) ?
                                                  8'(lit_b + src_b) : lit_b;
    else if (cmd.mat_wr) win_mem[wpos[WinAw-1:0]] <= src_b;
    if (cmd.rd_issue) rd_q <= win_mem[ra_q];
    else if (cmd.lit_rd) src_b <= win_mem[dsrc[WinAw-1:0]];
    else if (cmd.mat_rd) src_b <= win_mem[msrc[WinAw-1:0]];
  end

  // Chunk state and run counters.
  always_ff @(posedge clk) begin
    if (rst) begin
      lit_cnt <= '0;
      lit_pos <= '0;
      wpos <= '0;
      offs_cons <= '0;
      lens_cons <= '0;
      rec0 <= OffReset;
      rec1 <= OffReset;
      rec2 <= OffReset;
      last_off <= OffReset;
      lit_rem <= '0;
      mat_rem <= '0;
      run_off <= OffReset;
      src_ok <= 1'b0;
    end else begin
      if (cmd.capture) begin
        lit_rem <= (cmd_byte[1:0] == 2'd3) ? long_lit_len : {17'd0, cmd_byte[1:0]};
        run_off <= last_off;
      end
      if (cmd.set_tail) begin
        lit_rem <= limit - wpos;
        run_off <= last_off;
      end
      if (cmd.push) lit_cnt <= lit_cnt + 1'b1;
      if (cmd.hist) wpos <= wpos + 1'b1;
      if (cmd.lit_rd) begin
        src_ok <= !dsrc[19] && (dsrc[18:0] < WinBytes);
        lit_pos <= lit_pos + 1'b1;
        lit_rem <= lit_rem - 1'b1;
      end
      if (cmd.lit_wr || cmd.mat_wr) wpos <= wpos + 1'b1;
      if (cmd.mat_rd) mat_rem <= mat_rem - 1'b1;
      if (cmd.commit) begin
        mat_rem <= matchlen;
        run_off <= off_sel;
        last_off <= off_sel;
        rec0 <= off_sel;
        if (oidx != 2'd0) rec1 <= rec0;
        if (oidx[1]) rec2 <= rec1;
        if (oidx == 2'd3) offs_cons <= offs_cons + 1'b1;
        lens_cons <= lens_cons + 19'(lcode == 2'd3) + 19'(mcode == 4'hF);
      end
      if (cmd.clear) begin
        lit_cnt <= '0;
        lit_pos <= '0;
        offs_cons <= '0;
        lens_cons <= '0;
        rec0 <= OffReset;
        rec1 <= OffReset;
        rec2 <= OffReset;
        last_off <= OffReset;
      end
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) strobe <= 1'b0;
    else strobe <= cmd.done;
    if (cmd.done) begin
      status <= cmd.st;
      read_byte <= cmd.rb_sel ? rd_q : 8'd0;
    end
  end
  assign position = wpos;

`ifndef SYNTHESIS
  a_lit_bound: assert property (@(posedge clk) disable iff (rst)
    lit_pos <= lit_cnt) else $error("literal read past count");
  a_wpos_bound: assert property (@(posedge clk) disable iff (rst)
    wpos <= WinBytes) else $error("write position past window");
  a_commit_ok: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |-> (lit_rem == '0))
    else $error("commit before literals done");
`endif

endmodule

// File: tb/sv/tb_lz_run_executor_recent_offsets_top.sv
module tb_lz_run_executor_recent_offsets_top;
  import lzre_pkg::*;

  localparam int WinDepth = 262144;
  localparam int LitDepth = 131072;
  localparam int StallLimit = 2000000;
  localparam bit CfgLitMode = 1'b0;
  localparam bit CfgChunkEnd = 1'b1;
  localparam logic [2:0] OpSpareLo = 3'd5;
  localparam logic [2:0] OpSpareHi = 3'd7;

  typedef enum {KindItem, KindCfg, KindDrain} req_kind_t;

  typedef struct {
    req_kind_t kind;
    logic [2:0] op;
    logic [7:0] db;
    logic [7:0] cb;
    logic [18:0] ll;
    logic [18:0] lm;
    logic signed [18:0] no;
    logic [17:0] ra;
    logic [18:0] eo;
    logic [18:0] el;
    bit cidx;
    logic [18:0] cdata;
  } lz_req_t;

  typedef struct {
    logic [2:0] st;
    logic [18:0] pos;
    logic [7:0] rb;
  } lz_res_t;

  logic clk, rst, start, busy, cfg_we, cfg_index, strobe;
  logic [2:0] opcode, status;
  logic [7:0] data_byte, cmd_byte, read_byte;
  logic [18:0] long_lit_len, long_match_len, expected_offsets, expected_lengths;
  logic [18:0] cfg_data, position;
  logic signed [18:0] new_offset;
  logic [17:0] read_addr;

  lz_run_executor_recent_offsets_top DUT (.*);

  // Pending items and the results they are predicted to give.
  lz_req_t pending[$];
  lz_res_t awaited[$];
  bit taken = 1'b1;
  int idle_pct = 0;
  int nitems = 0;
  int errors = 0;
  int stall_cnt = 0;

  // Shadow of the block's state and registers.
  bit [7:0] win_mem [0:WinDepth-1];
  bit [7:0] lit_mem [0:LitDepth-1];
  int lcount, lrd, wpos, last_off;
  int roff [3];
  logic [18:0] ocons, lcons;
  bit lmode;
  int cend;

  function automatic void clear_chunk();
    for (int i = 0; i < 3; i++) roff[i] = -8;
    last_off = -8;
    ocons = '0;
    lcons = '0;
    lcount = 0;
    lrd = 0;
  endfunction

  function automatic int out_limit();
    return (cend < WinDepth) ? cend : WinDepth;
  endfunction

  // Append literals, adding the byte at the last offset in delta mode.
  function automatic void copy_literals(int n);
    bit [7:0] b;
    int src;
    for (int k = 0; k < n; k++) begin
      b = lit_mem[lrd];
      lrd++;
      if (!lmode) begin
        src = wpos + last_off;
        if (src >= 0 && src < WinDepth) b = b + win_mem[src];
      end
      win_mem[wpos] = b;
      wpos++;
    end
  endfunction

  function automatic logic [2:0] exec_command(lz_req_t r);
    logic [1:0] lc;
    logic [3:0] mc;
    logic [1:0] oi;
    longint nl, ml, lim, after, off;
    int i;
    lc = r.cb[1:0];
    mc = r.cb[5:2];
    oi = r.cb[7:6];
    nl = (lc == 2'd3) ? longint'(r.ll) : longint'(lc);
    ml = (mc == 4'hF) ? 14 + longint'(r.lm) : longint'(mc) + 2;
    lim = out_limit();
    if (lrd + nl > lcount) return StOverrun;
    after = wpos + nl;
    if (after > lim) return StLength;
    off = (oi == 2'd3) ? longint'(r.no) : longint'(roff[oi]);
    if (off >= 0 || -off > after) return StOffset;
    if (after + ml > lim) return StLength;
    copy_literals(int'(nl));
    if (oi == 2'd3) begin
      i = 2;
      ocons = ocons + 1'b1;
    end else begin
      i = oi;
    end
    for (; i > 0; i--) roff[i] = roff[i-1];
    roff[0] = int'(off);
    last_off = int'(off);
    if (lc == 2'd3) lcons = lcons + 1'b1;
    if (mc == 4'hF) lcons = lcons + 1'b1;
    for (longint k = 0; k < ml; k++) begin
      win_mem[wpos] = win_mem[wpos + int'(off)];
      wpos++;
    end
    return StOk;
  endfunction

  // Work out the result of one accepted item and update the shadow state.
  function automatic lz_res_t lz_apply(lz_req_t r);
    lz_res_t res;
    int lim;
    res.st = StOk;
    res.rb = '0;
    case (r.op)
      OpPush: begin
        if (lcount < LitDepth) begin
          lit_mem[lcount] = r.db;
          lcount++;
        end else begin
          res.st = StOverrun;
        end
      end
      OpCmd: res.st = exec_command(r);
      OpFinish: begin
        lim = out_limit();
        if (ocons != r.eo || lcons != r.el) res.st = StStream;
        else if (wpos > lim || lim - wpos != lcount - lrd) res.st = StLitCount;
        else copy_literals(lim - wpos);
        clear_chunk();
      end
      OpHist: begin
        if (wpos < WinDepth) begin
          win_mem[wpos] = r.db;
          wpos++;
        end else begin
          res.st = StLength;
        end
      end
      OpRead: res.rb = win_mem[r.ra];
      default: ;
    endcase
    res.pos = 19'(wpos);
    return res;
  endfunction

  // Clock.
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Driver: inputs change on the falling edge.
  always @(negedge clk) begin
    logic nstart;
    logic nwe;
    nstart = start;
    nwe = 1'b0;
    if (rst) begin
      nstart = 1'b0;
    end else if (cfg_we) begin
      nwe = 1'b0;
    end else if (start && !taken) begin
      nstart = 1'b1;
    end else begin
      nstart = 1'b0;
      if (pending.size() > 0) begin
        case (pending[0].kind)
          KindItem: begin
            if ($urandom_range(99) >= idle_pct) begin
              opcode <= pending[0].op;
              data_byte <= pending[0].db;
              cmd_byte <= pending[0].cb;
              long_lit_len <= pending[0].ll;
              long_match_len <= pending[0].lm;
              new_offset <= pending[0].no;
              read_addr <= pending[0].ra;
              expected_offsets <= pending[0].eo;
              expected_lengths <= pending[0].el;
              nstart = 1'b1;
              taken = 1'b0;
            end
          end
          KindCfg: begin
            if (!busy && awaited.size() == 0) begin
              cfg_index <= pending[0].cidx;
              cfg_data <= pending[0].cdata;
              nwe = 1'b1;
            end
          end
          default: begin
            if (!busy && awaited.size() == 0) void'(pending.pop_front());
          end
        endcase
      end
    end
    start <= nstart;
    cfg_we <= nwe;
  end

  // Monitor: results are checked and items accepted on the rising edge.
  always @(posedge clk) begin
    lz_res_t want;
    if (!rst) begin
      if (strobe) begin
        if (awaited.size() == 0) begin
          errors++;
          if (errors <= 10) $display("unexpected result: st=%0d pos=%0d rb=%0h",
                                     status, position, read_byte);
        end else begin
          want = awaited.pop_front();
          if (status !== want.st || position !== want.pos || read_byte !== want.rb) begin
            errors++;
            if (errors <= 10)
              $display("mismatch: st %0d/%0d pos %0d/%0d rb %0h/%0h (want/got)",
                       want.st, status, want.pos, position, want.rb, read_byte);
          end
        end
      end
      if (cfg_we) begin
        if (cfg_index == CfgLitMode) lmode = cfg_data[0];
        else cend = int'(cfg_data);
        void'(pending.pop_front());
      end
      if (start && !busy && !taken) begin
        awaited.push_back(lz_apply(pending[0]));
        void'(pending.pop_front());
        taken = 1'b1;
      end
    end
  end

  // Watchdog on cycles in which nothing is accepted and no result appears.
  always @(posedge clk) begin
    if ((start && !busy) || strobe) stall_cnt <= 0;
    else stall_cnt <= stall_cnt + 1;
    if (stall_cnt >= StallLimit) begin
      $display("FAIL");
      $finish;
    end
  end

  // Wait until the driver has taken the item, so the shadow state is current.
  task automatic send(lz_req_t r);
    pending.push_back(r);
    if (r.kind == KindItem) nitems++;
    while (pending.size() != 0) begin
      @(posedge clk);
      #1;
    end
  endtask

  function automatic lz_req_t rand_req(logic [2:0] op);
    lz_req_t r;
    r.kind = KindItem;
    r.op = op;
    r.db = 8'($urandom);
    r.cb = 8'($urandom);
    r.ll = 19'($urandom);
    r.lm = 19'($urandom);
    r.no = 19'($urandom);
    r.ra = (wpos > 0) ? 18'($urandom_range(0, wpos - 1)) : '0;
    r.eo = 19'($urandom);
    r.el = 19'($urandom);
    r.cidx = 1'b0;
    r.cdata = '0;
    return r;
  endfunction

  task automatic set_reg(bit idx, int val);
    lz_req_t r;
    r = rand_req(OpPush);
    r.kind = KindCfg;
    r.cidx = idx;
    r.cdata = 19'(val);
    send(r);
  endtask

  task automatic push_lits(int n);
    for (int i = 0; i < n; i++) send(rand_req(OpPush));
  endtask

  task automatic command(int lc, int mc, int oi, int nl, int lm, int back);
    lz_req_t r;
    r = rand_req(OpCmd);
    r.cb = {2'(oi), 4'(mc), 2'(lc)};
    if (lc == 3) r.ll = 19'(nl);
    if (mc == 15) r.lm = 19'(lm);
    if (oi == 3) r.no = -19'(back);
    send(r);
  endtask

  task automatic finish_chunk(bit honest);
    lz_req_t r;
    r = rand_req(OpFinish);
    if (honest) begin
      r.eo = ocons;
      r.el = lcons;
    end
    send(r);
  endtask

  // A command with its literals pushed first, sized to fit the chunk where there is room.
  task automatic good_command();
    int lc, mc, oi, nl, lm, ml, room, reach;
    lc = $urandom_range(0, 3);
    mc = $urandom_range(0, 15);
    oi = $urandom_range(0, 3);
    nl = (lc == 3) ? $urandom_range(0, 6) : lc;
    lm = ($urandom_range(9) == 0) ? $urandom_range(0, 40) : $urandom_range(0, 4);
    ml = (mc == 15) ? 14 + lm : mc + 2;
    room = out_limit() - wpos;
    if (nl + ml > room) begin
      lc = 0;
      nl = 0;
      mc = 0;
      ml = 2;
    end
    if (nl > lcount - lrd) push_lits(nl - (lcount - lrd));
    reach = wpos + nl;
    if (reach > 64) reach = 64;
    if (reach < 1) reach = 1;
    command(lc, mc, oi, nl, lm, $urandom_range(1, reach));
  endtask

  // One chunk: registers, commands mixed with other items, then the tail.
  task automatic run_chunk();
    int ncmd, tail;
    lz_req_t r;
    ncmd = $urandom_range(1, 12);
    set_reg(CfgLitMode, $urandom_range(0, 1));
    set_reg(CfgChunkEnd, wpos + ncmd * $urandom_range(4, 14));
    for (int i = 0; i < ncmd; i++) begin
      case ($urandom_range(0, 29))
        0, 1, 2: send(rand_req(OpRead));
        3: send(rand_req(OpHist));
        4: send(rand_req(3'($urandom_range(OpSpareLo, OpSpareHi))));
        5: send(rand_req(3'($urandom_range(0, 7))));
        default: good_command();
      endcase
    end
    tail = out_limit() - wpos - (lcount - lrd);
    if (tail > 0 && $urandom_range(9) != 0) push_lits(tail);
    finish_chunk($urandom_range(7) != 0);
    if ($urandom_range(3) == 0) begin
      r = rand_req(OpRead);
      send(r);
    end
  endtask

  initial begin
    lz_req_t r;
    start = 1'b0;
    cfg_we = 1'b0;
    cfg_index = 1'b0;
    cfg_data = '0;
    opcode = '0;
    data_byte = '0;
    cmd_byte = '0;
    long_lit_len = '0;
    long_match_len = '0;
    new_offset = '0;
    read_addr = '0;
    expected_offsets = '0;
    expected_lengths = '0;
    wpos = 0;
    lmode = 1'b1;
    cend = 0;
    clear_chunk();
    rst = 1'b1;
    repeat (6) @(negedge clk);
    rst = 1'b0;

    // Directed: delta literals whose source lies before the window start.
    set_reg(CfgLitMode, 0);
    set_reg(CfgChunkEnd, 64);
    push_lits(2);
    command(2, 0, 3, 0, 0, 1);
    // Raw history bytes at both extremes, reads and unused codes.
    r = rand_req(OpHist); r.db = 8'hFF; send(r);
    r = rand_req(OpHist); r.db = 8'h00; send(r);
    for (int i = 0; i < 6; i++) send(rand_req(OpHist));
    r = rand_req(OpRead); r.ra = '0; send(r);
    send(rand_req(OpSpareLo));
    send(rand_req(3'(OpSpareLo + 3'd1)));
    send(rand_req(OpSpareHi));
    r = rand_req(OpPush); r.db = 8'hFF; send(r);
    r = rand_req(OpPush); r.db = 8'h00; send(r);
    // A good command from the cache, then failing literal-count, match-length and offset checks, and a good match.
    command(2, 0, 0, 0, 0, 1);
    command(3, 0, 0, 19'h7FFFF, 0, 1);
    command(0, 15, 0, 0, 19'h7FFFF, 1);
    command(0, 0, 3, 0, 0, -5);
    command(0, 0, 3, 0, 0, 262144);
    command(0, 14, 3, 0, 0, 1);
    finish_chunk(1'b0);
    set_reg(CfgChunkEnd, wpos + 3);
    finish_chunk(1'b1);
    set_reg(CfgChunkEnd, 0);
    finish_chunk(1'b1);

    // Random chunks through the idling phases, with a full drain before each chunk started between 500 and 540 items.
    while (nitems < 1150) begin
      if (nitems < 300) idle_pct = 0;
      else if (nitems < 600) idle_pct = 47;
      else if (nitems < 850) idle_pct = 0;
      else idle_pct = 10;
      if (nitems > 500 && nitems < 540) begin
        r = rand_req(OpPush);
        r.kind = KindDrain;
        send(r);
      end
      run_chunk();
    end

    // Fill the rest of the window with one long match from the byte before.
    idle_pct = 0;
    set_reg(CfgLitMode, 1);
    set_reg(CfgChunkEnd, WinDepth);
    command(0, 15, 3, 0, WinDepth - wpos - 14, 1);
    send(rand_req(OpHist));
    r = rand_req(OpRead); r.ra = 18'h3FFFF; send(r);
    send(rand_req(OpRead));
    command(0, 0, 0, 0, 0, 1);
    finish_chunk(1'b1);

    while (pending.size() != 0 || awaited.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// File: lz_run_executor_recent_offsets_top.f
sv/lzre_pkg.sv
sv/lzre_ctrl.sv
sv/lzre_datapath.sv
sv/lz_run_executor_recent_offsets_top.sv
tb/sv/tb_lz_run_executor_recent_offsets_top.sv
